[sv/crc32cw_pkg.sv]
// shared constants and the fold matrix for the crc-32c word stream block
`timescale 1ns / 1ps
`default_nettype none

package crc32cw_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CRC_W  = 32;

    // reflected castagnoli polynomial
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82f6_3b78;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CRC_W-1:0]  crc_t;

    // one crc column per bit of the widened register
    typedef logic [WORD_W-1:0][CRC_W-1:0] fold_matrix_t;

    // column j is the 64-step bit-serial fold of a single set bit at position j
    function automatic fold_matrix_t build_fold_matrix();
        fold_matrix_t m;
        word_t        r;
        for (int j = 0; j < WORD_W; j++)
        begin
            r = word_t'(1) << j;
            for (int i = 0; i < WORD_W; i++)
            begin
                if (r[0])
                begin
                    r = (r >> 1) ^ word_t'(CRC_POLY);
                end
                else
                begin
                    r = r >> 1;
                end
            end
            m[j] = r[CRC_W-1:0];
        end
        return m;
    endfunction

    localparam fold_matrix_t FOLD_MATRIX = build_fold_matrix();

endpackage

`default_nettype wire

[sv/crc32cw_fold.sv]
// xor network that folds one 64-bit word into the running crc
`timescale 1ns / 1ps
`default_nettype none

module crc32cw_fold (
    input  wire crc32cw_pkg::crc_t  crc,
    input  wire crc32cw_pkg::word_t word,
    output crc32cw_pkg::crc_t       crc_out
);
    import crc32cw_pkg::*;

    word_t widened;

    // crc lands on the low half of the word
    assign widened = {{(WORD_W-CRC_W){1'b0}}, crc} ^ word;

    // each set bit contributes its precomputed column
    always_comb
    begin
        crc_out = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (widened[j])
            begin
                crc_out = crc_out ^ FOLD_MATRIX[j];
            end
        end
    end

endmodule

`default_nettype wire

[sv/crc32c_word_stream_top.sv]
// crc-32c over a stream of 64-bit words: input stage, fold network, result stage
//
// usage:
//   s_axis carries message words; tdata is the 64-bit word (least significant
//   byte folded first) and tlast marks the final word of a message.
//   m_axis carries one 32-bit crc per message (initial value zero, no final
//   xor), delivered after the word marked tlast.
// throughput and data path:
//   one word per cycle sustained while no last word waits for the result
//   register. a word is captured in the input register on its transfer,
//   and there a single xor network folds it into the running crc, which
//   for a last word goes to the result register on m_axis. the loop from
//   the crc register through the xor network back to itself sets this rate.
// reset:
//   rst_n low clears the running crc and both valid flags; nothing is pending.
// stalls:
//   words not marked last keep flowing while a result waits on m_axis. a last
//   word holds in the input register until the result register is free, and
//   s_axis_tready stays low while it waits.
`timescale 1ns / 1ps
`default_nettype none

module crc32c_word_stream_top (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [63:0] s_axis_tdata,   // [63:0] data_word
    input  wire        s_axis_tlast,   // last_word
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [31:0] crc_value
);
    import crc32cw_pkg::*;

    logic  in_vld_reg;
    logic  in_vld_next;
    word_t in_word_reg;
    logic  in_last_reg;
    crc_t  crc_reg;
    crc_t  crc_next;
    crc_t  folded;
    logic  out_vld_reg;
    logic  out_vld_next;
    crc_t  out_crc_reg;
    logic  out_free;
    logic  in_adv;
    logic  s_xfer;

    // handshake
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign in_adv        = in_vld_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_vld_reg || in_adv;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // fold network
    crc32cw_fold u_fold (
        .crc     (crc_reg),
        .word    (in_word_reg),
        .crc_out (folded)
    );

    // next state of the control
    always_comb
    begin
        in_vld_next  = s_xfer ? 1'b1 : (in_adv ? 1'b0 : in_vld_reg);
        out_vld_next = (in_adv && in_last_reg) ? 1'b1 : (out_free ? 1'b0 : out_vld_reg);
        crc_next     = crc_reg;
        if (in_adv)
        begin
            crc_next = in_last_reg ? '0 : folded;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            crc_reg     <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            crc_reg     <= crc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_word_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (in_adv && in_last_reg)
        begin
            out_crc_reg <= folded;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_crc_reg;

    // a finished message leaves the running crc cleared
    a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_adv && in_last_reg |=> crc_reg == '0)
        else $error("running crc not cleared after last word");

    // a word that is not last never disturbs a waiting result
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_adv && !in_last_reg && out_vld_reg && !m_axis_tready |=> $stable(out_crc_reg))
        else $error("waiting result changed by a non-last word");

    // a last word blocked by a stalled result stops the input side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && in_last_reg && out_vld_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while a last word is blocked");

endmodule

`default_nettype wire
